// File: design/spmf_pkg.sv
`timescale 1ns / 1ps

package spmf_pkg;

  // Sizing
  localparam int NUM_LEVELS = 4;
  localparam int FIFO_DEPTH = 16;
  localparam int MSG_WIDTH  = 16;

  // Fixed port field widths
  localparam int REQ_TYPE_W    = 1;
  localparam int LEVEL_W       = 2;
  localparam int WORD_W        = 16;
  localparam int STATUS_W      = 2;
  localparam int LEVEL_COUNT_W = 5;
  localparam int TOTAL_COUNT_W = 7;

  // Derived widths
  localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int TOT_W     = $clog2(NUM_LEVELS * FIFO_DEPTH + 1);
  localparam int ADDR_W    = LVL_IDX_W + PTR_W;
  localparam int RAM_DEPTH = NUM_LEVELS << PTR_W;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch the request word
    logic commit;    // update pointers, counts, memory
    logic load_now;  // result complete, load output register
    logic load_ram;  // load output register with memory read data
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic deq_hit;   // latched request is a dequeue that finds a word
    logic out_free;  // output register can take a result this cycle
  } dp_sts_t;

  // Pointer advance with wrap at the FIFO depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

endpackage

// File: design/strict_priority_multi_fifo.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Word fields
// -------   -----------------------   ---------------------------------------------
// request   req_valid_i / req_ready_o  req_type_i, level_i, message_word_i
// result    res_valid_o / res_ready_i  status_o, out_valid_o, out_message_o,
//                                      out_level_o, level_count_o, total_count_o
//
// An enqueue or a dequeue that finds all levels empty loads its result in the execute
// step; a dequeue that finds a word goes on to a read-wait step for the registered read
// of the message store. One request is in work at a time; a new request is accepted while
// the previous result waits in the output register. Reset clears all pointers and
// counts at once, no sweep; the message store is not cleared. A stalled result
// holds the next request in the execute step until the output register frees.

module strict_priority_multi_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  logic [spmf_pkg::REQ_TYPE_W-1:0]      req_type_i,
  input  logic [spmf_pkg::LEVEL_W-1:0]         level_i,
  input  logic [spmf_pkg::WORD_W-1:0]          message_word_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [spmf_pkg::STATUS_W-1:0]        status_o,
  output logic                                 out_valid_o,
  output logic [spmf_pkg::WORD_W-1:0]          out_message_o,
  output logic [spmf_pkg::LEVEL_W-1:0]         out_level_o,
  output logic [spmf_pkg::LEVEL_COUNT_W-1:0]   level_count_o,
  output logic [spmf_pkg::TOTAL_COUNT_W-1:0]   total_count_o
);

  import spmf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  spmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // queues, message store and result register
  spmf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .level_i       (level_i),
    .message_word_i(message_word_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .status_o      (status_o),
    .out_valid_o   (out_valid_o),
    .out_message_o (out_message_o),
    .out_level_o   (out_level_o),
    .level_count_o (level_count_o),
    .total_count_o (total_count_o)
  );

endmodule

// File: design/spmf_ram.sv
`timescale 1ns / 1ps

module spmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/spmf_ctrl.sv
`timescale 1ns / 1ps

module spmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  spmf_pkg::dp_sts_t sts_i,
  output spmf_pkg::dp_cmd_t cmd_o
);

  import spmf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_RDWAIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          if (sts_i.deq_hit) begin
            state_d = ST_RDWAIT;
          end else begin
            cmd_o.load_now = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_RDWAIT: begin
        cmd_o.load_ram = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // memory read data is only taken right after a committed dequeue
  a_rdwait_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDWAIT) |-> ($past(cmd_o.commit) && $past(sts_i.deq_hit)))
    else $error("read wait entered without committed dequeue");

  // a committed hit never loads the output register in the same cycle
  a_hit_no_direct_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && sts_i.deq_hit) |-> !cmd_o.load_now)
    else $error("dequeue hit loaded result before memory read");

endmodule

// File: design/spmf_dp.sv
`timescale 1ns / 1ps

module spmf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  spmf_pkg::dp_cmd_t                    cmd_i,
  output spmf_pkg::dp_sts_t                    sts_o,
  input  logic [spmf_pkg::REQ_TYPE_W-1:0]      req_type_i,
  input  logic [spmf_pkg::LEVEL_W-1:0]         level_i,
  input  logic [spmf_pkg::WORD_W-1:0]          message_word_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output logic [spmf_pkg::STATUS_W-1:0]        status_o,
  output logic                                 out_valid_o,
  output logic [spmf_pkg::WORD_W-1:0]          out_message_o,
  output logic [spmf_pkg::LEVEL_W-1:0]         out_level_o,
  output logic [spmf_pkg::LEVEL_COUNT_W-1:0]   level_count_o,
  output logic [spmf_pkg::TOTAL_COUNT_W-1:0]   total_count_o
);

  import spmf_pkg::*;

  // latched request
  req_e                 req_type_q;
  logic [LEVEL_W-1:0]   req_level_q;
  logic [MSG_WIDTH-1:0] req_word_q;

  // per-level queue state
  logic [PTR_W-1:0] head_q [NUM_LEVELS];
  logic [PTR_W-1:0] tail_q [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q  [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_nx [NUM_LEVELS];
  logic [TOT_W-1:0] total_q, total_d;

  // result register
  logic                     res_valid_q;
  status_e                  res_status_q, res_status_d;
  logic                     res_hit_q;
  logic [WORD_W-1:0]        res_msg_q;
  logic [LEVEL_W-1:0]       res_level_q;
  logic [LEVEL_COUNT_W-1:0] res_lcount_q, res_lcount_d;

  logic [LVL_IDX_W-1:0] lvl_idx;
  logic                 lvl_ok;
  logic                 any_held;
  logic [LVL_IDX_W-1:0] sel;
  logic                 enq_ok;
  logic                 deq_hit;
  logic [MSG_WIDTH-1:0] ram_rdata;

  // capture the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q  <= req_e'(req_type_i);
      req_level_q <= level_i;
      req_word_q  <= MSG_WIDTH'(message_word_i);
    end
  end

  assign lvl_idx = LVL_IDX_W'(req_level_q);
  assign lvl_ok  = (32'(req_level_q) < NUM_LEVELS);

  // priority encoder over non-empty levels, level 0 wins
  always_comb begin
    any_held = 1'b0;
    sel      = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        any_held = 1'b1;
        sel      = LVL_IDX_W'(i);
      end
    end
  end

  assign enq_ok  = (req_type_q == REQ_ENQ) && lvl_ok && (cnt_q[lvl_idx] != CNT_W'(FIFO_DEPTH));
  assign deq_hit = (req_type_q == REQ_DEQ) && any_held;

  // counts after the step
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_nx[i] = cnt_q[i];
      if (enq_ok && (lvl_idx == LVL_IDX_W'(i))) cnt_nx[i] = cnt_q[i] + CNT_W'(1);
      if (deq_hit && (sel == LVL_IDX_W'(i)))    cnt_nx[i] = cnt_q[i] - CNT_W'(1);
    end
    total_d = total_q;
    if (enq_ok)  total_d = total_q + TOT_W'(1);
    if (deq_hit) total_d = total_q - TOT_W'(1);
  end

  // result fields
  always_comb begin
    if (req_type_q == REQ_ENQ) res_status_d = enq_ok ? STS_OK : STS_FULL;
    else                       res_status_d = any_held ? STS_OK : STS_EMPTY;
    res_lcount_d = lvl_ok ? LEVEL_COUNT_W'(cnt_nx[lvl_idx]) : '0;
  end

  // queue state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_q[i] <= cnt_nx[i];
      end
      total_q <= total_d;
      if (enq_ok)  tail_q[lvl_idx] <= ptr_next(tail_q[lvl_idx]);
      if (deq_hit) head_q[sel]     <= ptr_next(head_q[sel]);
    end
  end

  // message store
  spmf_ram #(
    .WIDTH(MSG_WIDTH),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.commit && enq_ok),
    .wr_addr_i({lvl_idx, tail_q[lvl_idx]}),
    .wr_data_i(req_word_q),
    .rd_en_i  (cmd_i.commit && deq_hit),
    .rd_addr_i({sel, head_q[sel]}),
    .rd_data_o(ram_rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_now || cmd_i.load_ram) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q <= res_status_d;
      res_hit_q    <= deq_hit;
      res_level_q  <= deq_hit ? LEVEL_W'(sel) : '0;
      res_lcount_q <= res_lcount_d;
      res_msg_q    <= '0;
    end else if (cmd_i.load_ram) begin
      res_msg_q <= WORD_W'(ram_rdata);
    end
  end

  assign sts_o.deq_hit  = deq_hit;
  assign sts_o.out_free = !res_valid_q || res_ready_i;

  assign res_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign out_valid_o   = res_hit_q;
  assign out_message_o = res_msg_q;
  assign out_level_o   = res_level_q;
  assign level_count_o = res_lcount_q;
  assign total_count_o = TOTAL_COUNT_W'(total_q);

  // total never exceeds the combined capacity
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= NUM_LEVELS * FIFO_DEPTH)
    else $error("total count beyond capacity");

  // a delivered message always carries ok status
  a_hit_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_hit_q) |-> (res_status_q == STS_OK))
    else $error("dequeued word with non-ok status");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.load_now || cmd_i.load_ram) && res_valid_q |-> res_ready_i)
    else $error("pending result overwritten");

  // a committed dequeue hit always moves the total down by one
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && deq_hit) |=> (total_q == $past(total_q) - TOT_W'(1)))
    else $error("total count not decremented on dequeue");

endmodule
